// File: rtl/cld_pkg.sv
// Shared types, constants and keyword table for the console line command decoder.
// No dependencies; the datapath, controller and top level refer to this package by scoped names.
`default_nettype none

package cld_pkg;

	localparam int BUF_SIZE = 64;
	localparam int NUM_KEYWORDS = 13;
	localparam int KEY_LEN = 16;
	localparam int TABLE_ENTRIES = 13;
	localparam int KW_LIMIT = (NUM_KEYWORDS < TABLE_ENTRIES) ? NUM_KEYWORDS : TABLE_ENTRIES;
	localparam int KW_BYTES = 10;

	localparam int PTR_W = $clog2(BUF_SIZE);
	localparam int KW_IDX_W = $clog2(TABLE_ENTRIES);
	localparam int KEY_Y_W = $clog2(KEY_LEN);

	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] ACT_ECHO = 2'd0;
	localparam logic [1:0] ACT_ERASE = 2'd1;
	localparam logic [1:0] ACT_LINE = 2'd2;

	typedef struct packed {
		logic accept;
		logic restart;
		logic wp_zero;
		logic store;
		logic wp_dec;
		logic term_write;
		logic sel_ptr;
		logic ptr_clear;
		logic ptr_inc;
		logic cmp_start;
		logic cmp_step;
		logic kw_next;
		logic hit;
		logic emit;
		logic [1:0] emit_action;
		logic repeated;
	} cld_cmd_t;

	typedef struct packed {
		logic is_cr;
		logic is_bs;
		logic is_esc;
		logic is_lf;
		logic is_brk;
		logic wp_eff_zero;
		logic wp_eff_full;
		logic d_space;
		logic d_zero;
		logic kc_zero;
		logic d_eq_kc;
		logic ptr_last;
		logic y_last;
		logic k_last;
		logic out_free;
	} cld_sts_t;

	function automatic logic [KW_BYTES*8-1:0] kw_text(input logic [KW_IDX_W-1:0] k);
		logic [KW_BYTES*8-1:0] s;
		case (int'(k))
			0: s = {"rst", 56'h0};
			1: s = {"ls", 64'h0};
			2: s = {"bond", 48'h0};
			3: s = {"unbondc", 24'h0};
			4: s = {"rebondc", 24'h0};
			5: s = {"discovery", 8'h0};
			6: s = {"ledr", 48'h0};
			7: s = {"ledg", 48'h0};
			8: s = {"unbondn", 24'h0};
			9: s = {"osreset", 24'h0};
			10: s = {"osrestart", 8'h0};
			11: s = {"osinfo", 32'h0};
			12: s = {"loadcfg", 24'h0};
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] key_char(input logic [KW_IDX_W-1:0] k,
			input logic [KEY_Y_W-1:0] y);
		logic [KW_BYTES*8-1:0] s;
		int yi;
		s = kw_text(k);
		yi = int'(y);
		if (yi < KW_BYTES) begin
			return s[(KW_BYTES-1-yi)*8 +: 8];
		end
		return 8'h00;
	endfunction

	function automatic logic [7:0] init_char(input logic [PTR_W-1:0] a);
		case (int'(a))
			0: return "r";
			1: return "s";
			2: return "t";
			default: return 8'h00;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: rtl/cld_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module cld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/cld_datapath.sv
// Datapath: line buffer, write position, scan pointers, keyword table and result register.
// Depends on cld_pkg and cld_ram.
`default_nettype none

module cld_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire cld_pkg::cld_cmd_t cmd,
	output cld_pkg::cld_sts_t sts,
	input wire logic [7:0] rx_char,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] action,
	output logic [7:0] echo_char,
	output logic cmd_found,
	output logic [4:0] cmd_index,
	output logic [5:0] param_pos,
	output logic line_repeated
);

	logic [7:0] char_q;
	logic [cld_pkg::PTR_W-1:0] wp_q;
	logic [cld_pkg::PTR_W-1:0] wp_eff;
	logic [cld_pkg::BUF_SIZE-1:0] vld_q;
	logic [cld_pkg::PTR_W-1:0] ptr_q;
	logic [cld_pkg::PTR_W-1:0] x_q;
	logic [cld_pkg::PTR_W-1:0] start_q;
	logic [cld_pkg::KEY_Y_W-1:0] y_q;
	logic [cld_pkg::KW_IDX_W-1:0] k_q;
	logic hit_q;
	logic [cld_pkg::KW_IDX_W-1:0] idx_q;
	logic [cld_pkg::PTR_W-1:0] pos_q;

	logic ram_we;
	logic [cld_pkg::PTR_W-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic [cld_pkg::PTR_W-1:0] ram_raddr;
	logic [7:0] ram_rdata;
	logic rd_vld_q;
	logic [7:0] init_q;
	logic [7:0] rd_data;
	logic [7:0] kc;

	logic out_valid_q;
	logic [1:0] action_q;
	logic [7:0] echo_q;
	logic found_q;
	logic [4:0] index_q;
	logic [5:0] ppos_q;
	logic rep_q;

	assign wp_eff = cmd.restart ? '0 : wp_q;
	assign ram_we = cmd.store | cmd.term_write;
	assign ram_waddr = cmd.term_write ? wp_q : wp_eff;
	assign ram_wdata = cmd.term_write ? 8'h00 : char_q;
	assign ram_raddr = cmd.sel_ptr ? ptr_q : x_q;

	cld_ram #(
		.WIDTH(8),
		.DEPTH(cld_pkg::BUF_SIZE)
	) u_line_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_data = rd_vld_q ? ram_rdata : init_q;
	assign kc = cld_pkg::key_char(k_q, y_q);

	always_comb begin
		sts.is_cr = (char_q == cld_pkg::CH_CR);
		sts.is_bs = (char_q == cld_pkg::CH_BS);
		sts.is_esc = (char_q == cld_pkg::CH_ESC);
		sts.is_lf = (char_q == cld_pkg::CH_LF);
		sts.is_brk = (char_q == cld_pkg::CH_BRACKET);
		sts.wp_eff_zero = (wp_eff == '0);
		sts.wp_eff_full = (wp_eff == cld_pkg::PTR_W'(cld_pkg::BUF_SIZE - 1));
		sts.d_space = (rd_data == cld_pkg::CH_SPACE);
		sts.d_zero = (rd_data == 8'h00);
		sts.kc_zero = (kc == 8'h00);
		sts.d_eq_kc = (rd_data == kc);
		sts.ptr_last = (ptr_q == cld_pkg::PTR_W'(cld_pkg::BUF_SIZE - 1));
		sts.y_last = (y_q == cld_pkg::KEY_Y_W'(cld_pkg::KEY_LEN - 1));
		sts.k_last = (k_q == cld_pkg::KW_IDX_W'(cld_pkg::KW_LIMIT - 1));
		sts.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= cld_pkg::PTR_W'(cld_pkg::BUF_SIZE - 1);
			vld_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wp_zero) begin
				wp_q <= '0;
			end else if (cmd.store) begin
				wp_q <= wp_eff + 1'b1;
			end else if (cmd.wp_dec) begin
				wp_q <= wp_eff - 1'b1;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.term_write) begin
				hit_q <= 1'b0;
			end else if (cmd.hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[ram_raddr];
		init_q <= cld_pkg::init_char(ram_raddr);
		if (cmd.accept) begin
			char_q <= rx_char;
		end
		if (cmd.ptr_clear) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.cmp_start) begin
			start_q <= ptr_q;
			x_q <= ptr_q;
			y_q <= '0;
			k_q <= '0;
		end else if (cmd.cmp_step) begin
			x_q <= x_q + 1'b1;
			y_q <= y_q + 1'b1;
		end else if (cmd.kw_next) begin
			x_q <= start_q;
			y_q <= '0;
			k_q <= k_q + 1'b1;
		end
		if (cmd.hit) begin
			idx_q <= k_q;
			pos_q <= x_q;
		end
		if (cmd.emit) begin
			action_q <= cmd.emit_action;
			echo_q <= (cmd.emit_action == cld_pkg::ACT_ECHO) ? char_q : 8'h00;
			found_q <= (cmd.emit_action == cld_pkg::ACT_LINE) && hit_q;
			index_q <= ((cmd.emit_action == cld_pkg::ACT_LINE) && hit_q) ? 5'(idx_q) : 5'd0;
			ppos_q <= ((cmd.emit_action == cld_pkg::ACT_LINE) && hit_q) ? 6'(pos_q) : 6'd0;
			rep_q <= (cmd.emit_action == cld_pkg::ACT_LINE) && cmd.repeated;
		end
	end

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign echo_char = echo_q;
	assign cmd_found = found_q;
	assign cmd_index = index_q;
	assign param_pos = ppos_q;
	assign line_repeated = rep_q;

endmodule

`default_nettype wire

// File: rtl/cld_ctrl.sv
// Controller state machine: escape filtering, line editing decisions and the keyword walk.
// Depends on cld_pkg; drives the datapath through cld_cmd_t and reads cld_sts_t.
`default_nettype none

module cld_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output cld_pkg::cld_cmd_t cmd,
	input wire cld_pkg::cld_sts_t sts
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RD_SP = 3'd2;
	localparam logic [2:0] S_SP = 3'd3;
	localparam logic [2:0] S_RD_CMP = 3'd4;
	localparam logic [2:0] S_CMP = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q, state_d;
	logic esc_q, esc_d;
	logic bracket_q, bracket_d;
	logic repeat_q, repeat_d;
	logic need_result;

	assign in_stall = (state_q != S_IDLE);
	assign need_result = sts.is_bs ? !sts.wp_eff_zero : !sts.wp_eff_full;

	always_comb begin
		state_d = state_q;
		esc_d = esc_q;
		bracket_d = bracket_q;
		repeat_d = repeat_q;
		cmd = '0;
		cmd.restart = repeat_q;
		cmd.repeated = repeat_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (bracket_q) begin
					bracket_d = 1'b0;
					esc_d = 1'b0;
					state_d = S_IDLE;
				end else if (esc_q && sts.is_brk) begin
					bracket_d = 1'b1;
					state_d = S_IDLE;
				end else if (sts.is_esc) begin
					esc_d = 1'b1;
					state_d = S_IDLE;
				end else if (sts.is_lf) begin
					state_d = S_IDLE;
				end else if (sts.is_cr) begin
					esc_d = 1'b0;
					cmd.term_write = 1'b1;
					cmd.ptr_clear = 1'b1;
					state_d = S_RD_SP;
				end else if (!need_result) begin
					esc_d = 1'b0;
					repeat_d = 1'b0;
					cmd.wp_zero = repeat_q;
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					esc_d = 1'b0;
					repeat_d = 1'b0;
					cmd.emit = 1'b1;
					if (sts.is_bs) begin
						cmd.wp_dec = 1'b1;
						cmd.emit_action = cld_pkg::ACT_ERASE;
					end else begin
						cmd.store = 1'b1;
						cmd.emit_action = cld_pkg::ACT_ECHO;
					end
					state_d = S_IDLE;
				end
			end
			S_RD_SP: begin
				cmd.sel_ptr = 1'b1;
				state_d = S_SP;
			end
			S_SP: begin
				if (sts.d_space) begin
					if (sts.ptr_last) begin
						state_d = S_DONE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d = S_RD_SP;
					end
				end else begin
					cmd.cmp_start = 1'b1;
					state_d = S_RD_CMP;
				end
			end
			S_RD_CMP: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.kc_zero && (sts.d_space || sts.d_zero)) begin
					cmd.hit = 1'b1;
					state_d = S_DONE;
				end else if (!sts.d_eq_kc || sts.y_last) begin
					if (sts.k_last) begin
						state_d = S_DONE;
					end else begin
						cmd.kw_next = 1'b1;
						state_d = S_RD_CMP;
					end
				end else begin
					cmd.cmp_step = 1'b1;
					state_d = S_RD_CMP;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_action = cld_pkg::ACT_LINE;
					repeat_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			esc_q <= 1'b0;
			bracket_q <= 1'b0;
			repeat_q <= 1'b1;
		end else begin
			state_q <= state_d;
			esc_q <= esc_d;
			bracket_q <= bracket_d;
			repeat_q <= repeat_d;
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued while the output register is occupied");

	a_accept_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECIDE))
		else $error("accepted transaction not decoded next");

	a_bracket_after_esc: assert property (@(posedge clk) disable iff (!arst_n)
		bracket_q |-> esc_q)
		else $error("bracket flag set without a preceding escape");

	a_line_sets_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && (cmd.emit_action == cld_pkg::ACT_LINE)) |=> repeat_q)
		else $error("repeat flag not set after a decoded line");

endmodule

`default_nettype wire

// File: rtl/console_line_command_decoder_core.sv
// Console line command decoder, top level: controller plus datapath.
// An ordinary character is accepted in S_IDLE; S_DECIDE registers its result once the
// output register is free. Enter walks the line buffer, reading then testing each leading
// space and reading then comparing each character over the keyword table in turn.
// Asynchronous active-low reset; the line buffer then reads as "rst" through per-entry
// valid bits, with no clearing pass.
`default_nettype none

module console_line_command_decoder_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] rx_char,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] action,
	output logic [7:0] echo_char,
	output logic cmd_found,
	output logic [4:0] cmd_index,
	output logic [5:0] param_pos,
	output logic line_repeated
);

	cld_pkg::cld_cmd_t cmd;
	cld_pkg::cld_sts_t sts;

	cld_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.sts(sts)
	);

	cld_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.echo_char(echo_char),
		.cmd_found(cmd_found),
		.cmd_index(cmd_index),
		.param_pos(param_pos),
		.line_repeated(line_repeated)
	);

endmodule

`default_nettype wire

// File: dv/console_line_command_decoder_checker.sv
// Checker for the console line command decoder: watches both channels, predicts each
// transaction's result from its own copy of the line buffer and keyword table, and compares.
// Depends on cld_pkg for the buffer size, keyword limit, control characters and action codes.
module console_line_command_decoder_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] rx_char,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] action,
	input logic [7:0] echo_char,
	input logic cmd_found,
	input logic [4:0] cmd_index,
	input logic [5:0] param_pos,
	input logic line_repeated,
	output int fail_count,
	output int outstanding,
	output int accepted_total
);
	timeunit 1ns;
	timeprecision 1ps;

	import cld_pkg::*;

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] ch;
		logic found;
		logic [4:0] idx;
		logic [5:0] pos;
		logic rep;
	} console_result_t;

	string keywords [TABLE_ENTRIES] = '{"rst", "ls", "bond", "unbondc", "rebondc", "discovery",
		"ledr", "ledg", "unbondn", "osreset", "osrestart", "osinfo", "loadcfg"};

	console_result_t expected_q [$];
	logic [7:0] line_buf [BUF_SIZE];
	int wr_pos;
	bit rep_pending;
	bit esc_seen;
	bit brk_seen;
	int errors;
	int accepted;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < 100) begin
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		end
		errors++;
	endtask

	function automatic bit find_keyword(output int idx, output int pos);
		int first;
		int x;
		logic [7:0] kc;
		logic [7:0] lc;
		idx = 0;
		pos = 0;
		first = 0;
		while (first < BUF_SIZE && line_buf[first] == CH_SPACE) first++;
		if (first >= BUF_SIZE) begin
			return 1'b0;
		end
		for (int k = 0; k < KW_LIMIT; k++) begin
			x = first;
			for (int y = 0; y < KEY_LEN; y++) begin
				kc = (y < keywords[k].len()) ? keywords[k][y] : 8'h00;
				lc = (x < BUF_SIZE) ? line_buf[x] : 8'h00;
				if (kc == 8'h00 && (lc == CH_SPACE || lc == 8'h00)) begin
					idx = k;
					pos = x;
					return 1'b1;
				end
				if (lc != kc) begin
					break;
				end
				x++;
			end
		end
		return 1'b0;
	endfunction

	task automatic apply_char(input logic [7:0] c);
		console_result_t r;
		int idx;
		int pos;
		bit hit;
		r = '0;
		if (brk_seen) begin
			brk_seen = 1'b0;
			esc_seen = 1'b0;
			return;
		end
		if (esc_seen && c == CH_BRACKET) begin
			brk_seen = 1'b1;
			return;
		end
		if (c == CH_ESC) begin
			esc_seen = 1'b1;
			return;
		end
		if (c == CH_LF) begin
			return;
		end
		esc_seen = 1'b0;
		if (c == CH_CR) begin
			if (wr_pos >= BUF_SIZE) begin
				wr_pos = BUF_SIZE - 1;
			end
			line_buf[wr_pos] = 8'h00;
			hit = find_keyword(idx, pos);
			r.act = ACT_LINE;
			r.found = hit;
			if (hit) begin
				r.idx = 5'(idx);
				r.pos = 6'(pos);
			end
			r.rep = rep_pending;
			rep_pending = 1'b1;
			expected_q.push_back(r);
			return;
		end
		if (rep_pending) begin
			rep_pending = 1'b0;
			wr_pos = 0;
		end
		if (c == CH_BS) begin
			if (wr_pos > 0) begin
				wr_pos--;
				r.act = ACT_ERASE;
				expected_q.push_back(r);
			end
			return;
		end
		if (wr_pos < BUF_SIZE - 1) begin
			line_buf[wr_pos] = c;
			wr_pos++;
			r.act = ACT_ECHO;
			r.ch = c;
			expected_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		console_result_t want;
		if (!arst_n) begin
			foreach (line_buf[i]) line_buf[i] = 8'h00;
			line_buf[0] = "r";
			line_buf[1] = "s";
			line_buf[2] = "t";
			wr_pos = BUF_SIZE - 1;
			rep_pending = 1'b1;
			esc_seen = 1'b0;
			brk_seen = 1'b0;
			expected_q.delete();
			errors = 0;
			accepted = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result transaction with nothing expected, action", action, -1);
				end else begin
					want = expected_q.pop_front();
					if (action !== want.act) report_mismatch("action", action, want.act);
					if (echo_char !== want.ch) report_mismatch("echo_char", echo_char, want.ch);
					if (cmd_found !== want.found) report_mismatch("cmd_found", cmd_found, want.found);
					if (cmd_index !== want.idx) report_mismatch("cmd_index", cmd_index, want.idx);
					if (param_pos !== want.pos) report_mismatch("param_pos", param_pos, want.pos);
					if (line_repeated !== want.rep) begin
						report_mismatch("line_repeated", line_repeated, want.rep);
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_char(rx_char);
				accepted++;
			end
		end
		fail_count <= errors;
		outstanding <= expected_q.size();
		accepted_total <= accepted;
	end

endmodule

// File: dv/console_line_command_decoder_core_tb.sv
// Testbench top for the console line command decoder: clock, reset, character stimulus and
// a randomly stalling receiver; the checker beside the block predicts and compares.
// Depends on cld_pkg, console_line_command_decoder_core and console_line_command_decoder_checker.
module console_line_command_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cld_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int TARGET_ITEMS = 1750;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] rx_char = 8'h00;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [1:0] action;
	logic [7:0] echo_char;
	logic cmd_found;
	logic [4:0] cmd_index;
	logic [5:0] param_pos;
	logic line_repeated;

	int fail_count;
	int outstanding;
	int accepted_total;
	int send_idle_pct = 37;
	int recv_idle_pct = 62;
	int hold_request = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	string kw_names [TABLE_ENTRIES] = '{"rst", "ls", "bond", "unbondc", "rebondc", "discovery",
		"ledr", "ledg", "unbondn", "osreset", "osrestart", "osinfo", "loadcfg"};

	logic [7:0] opening_chars [23] = '{CH_CR, CH_CR, CH_ESC, CH_BRACKET, "A", CH_LF, CH_BS,
		CH_SPACE, "b", "o", "n", "d", CH_BS, "d", CH_SPACE, 8'hFF, CH_CR, 8'h00, "r", CH_CR,
		CH_ESC, "x", CH_CR};

	console_line_command_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.echo_char(echo_char),
		.cmd_found(cmd_found),
		.cmd_index(cmd_index),
		.param_pos(param_pos),
		.line_repeated(line_repeated)
	);

	console_line_command_decoder_checker decode_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.echo_char(echo_char),
		.cmd_found(cmd_found),
		.cmd_index(cmd_index),
		.param_pos(param_pos),
		.line_repeated(line_repeated),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.accepted_total(accepted_total)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (hold_taken != hold_request) begin
			hold_taken = hold_request;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char <= c;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic type_char(input logic [7:0] c);
		send_char(c);
		case ($urandom_range(99))
			0, 1, 2: begin
				send_char(CH_ESC);
				send_char(CH_BRACKET);
				send_char(8'($urandom()));
			end
			3, 4: begin
				send_char(CH_LF);
			end
			5, 6, 7, 8: begin
				send_char(8'($urandom_range(126, 33)));
				send_char(CH_BS);
			end
			default: begin
			end
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_line();
		int kind;
		int k;
		int cut;
		kind = $urandom_range(99);
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(3, 1)) type_char(CH_SPACE);
		end
		if (kind < 60) begin
			k = $urandom_range(TABLE_ENTRIES - 1);
			cut = kw_names[k].len();
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(cut, 0);
			end
			for (int i = 0; i < cut; i++) type_char(kw_names[k][i]);
			if ($urandom_range(9) == 0) begin
				type_char(8'($urandom_range(122, 97)));
			end
			if ($urandom_range(1) == 0) begin
				type_char(CH_SPACE);
				repeat ($urandom_range(8)) type_char(8'($urandom_range(126, 32)));
			end
		end else if (kind < 70) begin
			repeat ($urandom_range(8, 1)) type_char(8'($urandom_range(126, 33)));
		end else if (kind < 78) begin
		end else if (kind < 83) begin
			repeat ($urandom_range(6, 1)) type_char(CH_SPACE);
		end else if (kind < 88) begin
			repeat ($urandom_range(75, 60)) send_char(8'($urandom_range(126, 32)));
		end else if (kind < 92) begin
			repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(126, 33)));
			repeat ($urandom_range(6, 1)) send_char(CH_BS);
		end else begin
			repeat ($urandom_range(10, 1)) send_char(8'($urandom()));
		end
		send_char(CH_CR);
	endtask

	initial begin
		int phase;
		phase = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening_chars[i]) send_char(opening_chars[i]);
		while (accepted_total < TARGET_ITEMS) begin
			if (phase == 0 && accepted_total >= TARGET_ITEMS / 3) begin
				phase = 1;
				send_idle_pct = 62;
				recv_idle_pct = 37;
				// The receiver holds off while a long line keeps arriving, so the block backs up.
				hold_request++;
				repeat (70) send_char(8'($urandom_range(126, 32)));
				send_char(CH_CR);
			end
			if (phase == 1 && accepted_total >= 2 * TARGET_ITEMS / 3) begin
				phase = 2;
				wait_drained();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_line();
		end
		wait_drained();
		repeat (600) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/cld_pkg.sv
rtl/cld_ram.sv
rtl/cld_datapath.sv
rtl/cld_ctrl.sv
rtl/console_line_command_decoder_core.sv
dv/console_line_command_decoder_checker.sv
dv/console_line_command_decoder_core_tb.sv
